/* rtl/core/vector_tile_path_encoder_top_defines.svh */
// assertion macros for the vector tile path encoder
`ifndef VECTOR_TILE_PATH_ENCODER_TOP_DEFINES_SVH
`define VECTOR_TILE_PATH_ENCODER_TOP_DEFINES_SVH

// checked only out of reset
`define VTPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define VTPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/vtpe_pkg.sv */
// types, constants and helper functions of the vector tile path encoder
package vtpe_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int RES_MAX        = 9;
    localparam int RES_IW         = $clog2(RES_MAX);
    localparam int RES_CW         = $clog2(RES_MAX + 1);

    localparam logic [31:0] CMD_MOVETO1 = 32'd9;
    localparam logic [2:0]  CMD_LINETO  = 3'd2;
    localparam logic [31:0] CMD_CLOSE1  = 32'd15;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_SCALE_Q16 = 3'd2,
        CFG_RAW_MODE  = 3'd3,
        CFG_RING_MODE = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_PATCH  = 2'd1,
        ACT_TRUNC  = 2'd2
    } t_action;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               new_feature;
        logic               last_point;
    } t_in;

    typedef struct packed {
        t_action     action;
        logic [13:0] position;
        logic [31:0] word;
        logic        line_done;
        logic        line_ok;
        logic        last_of_run;
    } t_out;

    function automatic logic [31:0] zigzag(input logic [31:0] n);
        zigzag = {n[30:0], 1'b0} ^ {32{n[31]}};
    endfunction

    // magnitude of a signed 33-bit difference, 2^32 fits
    function automatic logic [32:0] mag33(input logic [32:0] d);
        mag33 = d[32] ? (~d + 33'd1) : d;
    endfunction

    // round half away from zero, then saturate to signed 32 bits
    function automatic logic [31:0] tile_round(input logic [63:0] prod, input logic hi,
                                               input logic [31:0] scale, input logic neg);
        logic [65:0] sum;
        logic [49:0] r;
        sum = {2'b00, prod} + (hi ? {2'b00, scale, 32'd0} : 66'd0) + 66'h8000;
        r   = sum[65:16];
        if (neg) begin
            tile_round = (r >= 50'h8000_0000) ? 32'h8000_0000 : (32'd0 - r[31:0]);
        end else begin
            tile_round = (r > 50'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end
    endfunction

    function automatic t_out mk_res(input t_action act, input logic [13:0] pos,
                                    input logic [31:0] w, input logic done, input logic ok);
        mk_res = '{action: act, position: pos, word: w, line_done: done, line_ok: ok,
                   last_of_run: 1'b0};
    endfunction

endpackage

/* rtl/core/vector_tile_path_encoder_top.sv */
// vector tile path encoder: tile mapping pipeline, command encoder and result queue
// path to the first result: mapping stages s1 to s4, then the result queue, then the output register
// input side: one transaction per cycle enters the four-stage mapping pipeline while o_in_stall is low
// output side: the encoder takes the next item only once at most one result of the last is left to
// drain, bound by the single result port draining one word per cycle while i_out_stall is low
// reset: synchronous active low; control and config registers take their reset values, cursor zero
`include "vector_tile_path_encoder_top_defines.svh"
module vector_tile_path_encoder_top #(
    parameter int MAX_POINTS = vtpe_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vtpe_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vtpe_pkg::t_out     o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import vtpe_pkg::*;

    localparam int SEG_W = $clog2(MAX_POINTS);
    localparam int WC_W  = $clog2(2 * MAX_POINTS + 4);

    // configuration
    logic [31:0] r_origin_x, r_origin_y, r_scale;
    logic        r_raw, r_ring;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_scale    <= 32'h0001_0000;
            r_raw      <= 1'b0;
            r_ring     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:  r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin_y <= i_cfg_data;
                CFG_SCALE_Q16: r_scale    <= i_cfg_data;
                CFG_RAW_MODE:  r_raw      <= i_cfg_data[0];
                CFG_RING_MODE: r_ring     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // mapping pipeline
    logic        r_v1, r_v2, r_v3, r_v4;
    t_in         r_s1, r_s2, r_s3, r_s4;
    logic [32:0] r_mag_x, r_mag_y;
    logic        r_neg2_x, r_neg2_y, r_neg3_x, r_neg3_y, r_hi_x, r_hi_y;
    logic [63:0] r_prod_x, r_prod_y;
    logic [31:0] r_px, r_py;
    logic        load1, load2, load3, load4, enc_take, buf_free, drain;
    logic [32:0] dx, dy;

    assign load4 = !r_v4 || enc_take;
    assign load3 = !r_v3 || load4;
    assign load2 = !r_v2 || load3;
    assign load1 = !r_v1 || load2;
    assign o_in_stall = !load1;

    assign dx = {r_s1.x_coord[31], r_s1.x_coord} - {r_origin_x[31], r_origin_x};
    assign dy = {r_origin_y[31], r_origin_y} - {r_s1.y_coord[31], r_s1.y_coord};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (load1) r_v1 <= i_in_valid;
            if (load2) r_v2 <= r_v1;
            if (load3) r_v3 <= r_v2;
            if (load4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) r_s1 <= i_in_data;
        if (load2) begin
            r_s2     <= r_s1;
            r_mag_x  <= mag33(dx);
            r_mag_y  <= mag33(dy);
            r_neg2_x <= dx[32];
            r_neg2_y <= dy[32];
        end
        if (load3) begin
            r_s3     <= r_s2;
            r_prod_x <= r_mag_x[31:0] * r_scale;
            r_prod_y <= r_mag_y[31:0] * r_scale;
            r_hi_x   <= r_mag_x[32];
            r_hi_y   <= r_mag_y[32];
            r_neg3_x <= r_neg2_x;
            r_neg3_y <= r_neg2_y;
        end
        if (load4) begin
            r_s4 <= r_s3;
            r_px <= r_raw ? r_s3.x_coord : tile_round(r_prod_x, r_hi_x, r_scale, r_neg3_x);
            r_py <= r_raw ? r_s3.y_coord : tile_round(r_prod_y, r_hi_y, r_scale, r_neg3_y);
        end
    end

    // encoder state
    logic [31:0]      r_cur_x, r_cur_y, r_ls_x, r_ls_y, r_pv_x, r_pv_y, r_f_x, r_f_y;
    logic [31:0]      n_cur_x, n_cur_y, n_ls_x, n_ls_y, n_pv_x, n_pv_y, n_f_x, n_f_y;
    logic [SEG_W-1:0] r_seg, n_seg;
    logic [WC_W-1:0]  r_wc, n_wc;
    logic             r_inl, n_inl;
    t_out             n_list [RES_MAX];
    logic [RES_CW-1:0] n_cnt;

    always_comb begin
        n_cur_x = r_cur_x;  n_cur_y = r_cur_y;
        n_ls_x  = r_ls_x;   n_ls_y  = r_ls_y;
        n_pv_x  = r_pv_x;   n_pv_y  = r_pv_y;
        n_f_x   = r_f_x;    n_f_y   = r_f_y;
        n_seg   = r_seg;
        n_wc    = r_wc;
        n_inl   = r_inl;
        n_cnt   = '0;
        for (int i = 0; i < RES_MAX; i++) n_list[i] = '0;

        if (r_s4.new_feature) begin
            if (n_inl) begin
                n_list[RES_IW'(n_cnt)] = mk_res(ACT_TRUNC, 14'd0, 32'd0, 1'b1, 1'b0);
                n_cnt   = n_cnt + 1'b1;
                n_cur_x = n_ls_x;
                n_cur_y = n_ls_y;
                n_inl   = 1'b0;
                n_seg   = '0;
                n_wc    = '0;
            end
            n_cur_x = '0;
            n_cur_y = '0;
        end

        // in ring mode the final point only closes the ring
        if (!(r_s4.last_point && r_ring)) begin
            if (!n_inl) begin
                n_inl  = 1'b1;
                n_seg  = '0;
                n_wc   = '0;
                n_ls_x = n_cur_x;
                n_ls_y = n_cur_y;
                n_f_x  = r_px;
                n_f_y  = r_py;
                n_pv_x = n_cur_x;
                n_pv_y = n_cur_y;
                n_cur_x = r_px;
                n_cur_y = r_py;
            end else if (!(r_px == n_cur_x && r_py == n_cur_y)
                         && n_seg < SEG_W'(MAX_POINTS - 1)) begin
                n_seg = n_seg + 1'b1;
                if (n_seg == SEG_W'(1)) begin
                    n_list[RES_IW'(n_cnt)] = mk_res(ACT_APPEND, 14'(n_wc), CMD_MOVETO1,
                                                    1'b0, 1'b0);
                    n_cnt = n_cnt + 1'b1;
                    n_wc  = n_wc + 1'b1;
                    n_list[RES_IW'(n_cnt)] = mk_res(ACT_APPEND, 14'(n_wc),
                                                    zigzag(n_cur_x - n_ls_x), 1'b0, 1'b0);
                    n_cnt = n_cnt + 1'b1;
                    n_wc  = n_wc + 1'b1;
                    n_list[RES_IW'(n_cnt)] = mk_res(ACT_APPEND, 14'(n_wc),
                                                    zigzag(n_cur_y - n_ls_y), 1'b0, 1'b0);
                    n_cnt = n_cnt + 1'b1;
                    n_wc  = n_wc + 1'b1;
                    n_list[RES_IW'(n_cnt)] = mk_res(ACT_APPEND, 14'(n_wc),
                                                    {29'd0, CMD_LINETO}, 1'b0, 1'b0);
                    n_cnt = n_cnt + 1'b1;
                    n_wc  = n_wc + 1'b1;
                end
                n_list[RES_IW'(n_cnt)] = mk_res(ACT_APPEND, 14'(n_wc),
                                                zigzag(r_px - n_cur_x), 1'b0, 1'b0);
                n_cnt = n_cnt + 1'b1;
                n_wc  = n_wc + 1'b1;
                n_list[RES_IW'(n_cnt)] = mk_res(ACT_APPEND, 14'(n_wc),
                                                zigzag(r_py - n_cur_y), 1'b0, 1'b0);
                n_cnt   = n_cnt + 1'b1;
                n_wc    = n_wc + 1'b1;
                n_pv_x  = n_cur_x;
                n_pv_y  = n_cur_y;
                n_cur_x = r_px;
                n_cur_y = r_py;
            end
        end

        if (r_s4.last_point) begin
            if (!n_inl) n_seg = '0;
            // closing duplicate of the first point
            if (r_ring && n_seg != '0 && n_f_x == n_cur_x && n_f_y == n_cur_y) begin
                n_wc = n_wc - WC_W'(2);
                n_list[RES_IW'(n_cnt)] = mk_res(ACT_TRUNC, 14'(n_wc), 32'd0, 1'b0, 1'b0);
                n_cnt   = n_cnt + 1'b1;
                n_seg   = n_seg - 1'b1;
                n_cur_x = n_pv_x;
                n_cur_y = n_pv_y;
            end
            if (n_inl && n_seg >= (r_ring ? SEG_W'(2) : SEG_W'(1))) begin
                if (r_ring) begin
                    n_list[RES_IW'(n_cnt)] = mk_res(ACT_PATCH, 14'd3,
                                                    32'({n_seg, CMD_LINETO}), 1'b0, 1'b0);
                    n_cnt = n_cnt + 1'b1;
                    n_list[RES_IW'(n_cnt)] = mk_res(ACT_APPEND, 14'(n_wc), CMD_CLOSE1,
                                                    1'b1, 1'b1);
                    n_cnt = n_cnt + 1'b1;
                end else begin
                    n_list[RES_IW'(n_cnt)] = mk_res(ACT_PATCH, 14'd3,
                                                    32'({n_seg, CMD_LINETO}), 1'b1, 1'b1);
                    n_cnt = n_cnt + 1'b1;
                end
            end else begin
                n_list[RES_IW'(n_cnt)] = mk_res(ACT_TRUNC, 14'd0, 32'd0, 1'b1, 1'b0);
                n_cnt   = n_cnt + 1'b1;
                n_cur_x = n_ls_x;
                n_cur_y = n_ls_y;
            end
            n_inl = 1'b0;
            n_seg = '0;
            n_wc  = '0;
        end

        if (n_cnt != '0) n_list[RES_IW'(n_cnt - 1'b1)].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;  r_cur_y <= '0;
            r_ls_x  <= '0;  r_ls_y  <= '0;
            r_pv_x  <= '0;  r_pv_y  <= '0;
            r_f_x   <= '0;  r_f_y   <= '0;
            r_seg   <= '0;
            r_wc    <= '0;
            r_inl   <= 1'b0;
        end else if (enc_take) begin
            r_cur_x <= n_cur_x;  r_cur_y <= n_cur_y;
            r_ls_x  <= n_ls_x;   r_ls_y  <= n_ls_y;
            r_pv_x  <= n_pv_x;   r_pv_y  <= n_pv_y;
            r_f_x   <= n_f_x;    r_f_y   <= n_f_y;
            r_seg   <= n_seg;
            r_wc    <= n_wc;
            r_inl   <= n_inl;
        end
    end

    // result queue and output register
    t_out              r_buf [RES_MAX];
    logic [RES_CW-1:0] r_cnt, r_rd;
    t_out              r_out;
    logic              r_ov;

    assign drain    = (r_rd != r_cnt) && (!r_ov || !i_out_stall);
    assign buf_free = (r_rd == r_cnt) || ((r_rd + 1'b1 == r_cnt) && drain);
    assign enc_take = r_v4 && buf_free;

    always_ff @(posedge i_clk) begin
        if (enc_take) begin
            for (int i = 0; i < RES_MAX; i++) r_buf[i] <= n_list[i];
        end
        if (drain) r_out <= r_buf[RES_IW'(r_rd)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (enc_take) begin
                r_cnt <= n_cnt;
                r_rd  <= '0;
            end else if (drain) begin
                r_rd <= r_rd + 1'b1;
            end
            if (drain) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `VTPE_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= RES_CW'(RES_MAX), "result count overflow")
    `VTPE_ASSERT(a_rd_le_cnt, i_clk, i_rst_n, r_rd <= r_cnt, "read pointer past count")
    `VTPE_ASSERT(a_take_free, i_clk, i_rst_n, enc_take |=> (r_rd == '0), "queue overwritten")
    `VTPE_ASSERT(a_ok_done, i_clk, i_rst_n, (r_ov && r_out.line_ok) |-> r_out.line_done, "ok/done")
    `VTPE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!r_ov && !r_v4), "busy after reset")

endmodule
